@@ rtl/keyframe_vec3_interpolator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Keyframe interpolator assertion macros
// Shared property forms for the checker, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VEC3_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_VEC3_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define KVI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kvi_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Widths, register and component codes, and control structs.
// ----------------------------------------------------------------------------
package kvi_pkg;

    localparam int MAX_KEYS_DEF = 64;

    localparam int DATA_W  = 32;
    localparam int VEC_W   = 3 * DATA_W;
    localparam int IDX_W   = 6;
    localparam int KC_W    = 7;
    localparam int FRAC_W  = 16;
    localparam int BLEND_W = FRAC_W + 1;
    localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

    localparam logic [BLEND_W-1:0] ONE_Q16 = BLEND_W'(1) << FRAC_W;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT = '0;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic diff_en;
        logic mul_en;
    } lerp_ctl_t;

endpackage

@@ rtl/keyframe_vec3_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// Keyframe vec3 interpolator
// Keyframe track with a sequential segment search and a linear blend.
// ----------------------------------------------------------------------------
// A load request (mode 0) writes one keyframe and leaves the block ready.
// A query request (mode 1) runs a search that reads one key time per cycle
// from the time memory's single read port; the blend factor comes from a
// divider that makes one quotient bit per cycle and is skipped when the
// factor clamps, and one shared multiplier handles the three components in
// turn, each through the difference, multiply and add states. A single-key
// track skips the search and the divider. The block takes no request while
// a query is in flight; a finished result waits in the output register.
// ----------------------------------------------------------------------------
module keyframe_vec3_interpolator_unit #(
    parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kvi_pkg::PADDR_W-1:0]         paddr,
    input  logic [kvi_pkg::PDATA_W-1:0]         pwdata,
    output logic [kvi_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [kvi_pkg::IDX_W-1:0]           s_key_index,
    input  logic [kvi_pkg::DATA_W-1:0]          s_key_time,
    input  logic signed [kvi_pkg::DATA_W-1:0]   s_key_x,
    input  logic signed [kvi_pkg::DATA_W-1:0]   s_key_y,
    input  logic signed [kvi_pkg::DATA_W-1:0]   s_key_z,
    input  logic [kvi_pkg::DATA_W-1:0]          s_query_time,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [kvi_pkg::DATA_W-1:0]   m_out_x,
    output logic signed [kvi_pkg::DATA_W-1:0]   m_out_y,
    output logic signed [kvi_pkg::DATA_W-1:0]   m_out_z,
    output logic [kvi_pkg::IDX_W-1:0]           m_segment,
    output logic [kvi_pkg::BLEND_W-1:0]         m_blend
);

    localparam int AW        = $clog2(MAX_KEYS);
    localparam int DATA_W    = kvi_pkg::DATA_W;
    localparam int VEC_W     = kvi_pkg::VEC_W;
    localparam int IDX_W     = kvi_pkg::IDX_W;
    localparam int KC_W      = kvi_pkg::KC_W;
    localparam int BLEND_W   = kvi_pkg::BLEND_W;
    localparam int FRAC_W    = kvi_pkg::FRAC_W;
    localparam int PDATA_W   = kvi_pkg::PDATA_W;
    localparam int PADDR_W   = kvi_pkg::PADDR_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_CLAMP = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_VA    = 4'd6;
    localparam logic [3:0] S_VB    = 4'd7;
    localparam logic [3:0] S_VC    = 4'd8;
    localparam logic [3:0] S_LDIFF = 4'd9;
    localparam logic [3:0] S_LMUL  = 4'd10;
    localparam logic [3:0] S_LADD  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]               state_reg, state_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     pend_reg;
    logic [KC_W-1:0]          key_count_reg;

    logic [DATA_W-1:0]        q_reg;
    logic [AW-1:0]            last_reg;
    logic [AW-1:0]            probe_reg;
    logic [AW-1:0]            pend_idx_reg;
    logic [DATA_W-1:0]        tprev_reg;
    logic [DATA_W-1:0]        ti_reg;
    logic [DATA_W-1:0]        tn_reg;
    logic [AW-1:0]            seg_reg;
    logic                     single_reg;
    logic signed [DATA_W:0]   num_reg;
    logic signed [DATA_W:0]   den_reg;
    logic [BLEND_W-1:0]       blend_reg;
    logic [VEC_W-1:0]         a_vec_reg;
    logic [VEC_W-1:0]         b_vec_reg;
    logic [1:0]               comp_reg;
    logic [DATA_W-1:0]        res_x_reg, res_y_reg, res_z_reg;

    logic [DATA_W-1:0]        out_x_reg, out_y_reg, out_z_reg;
    logic [IDX_W-1:0]         out_seg_reg;
    logic [BLEND_W-1:0]       out_blend_reg;

    logic                     cfg_wr;
    logic                     cfg_sel;
    logic                     s_fire;
    logic                     load_wr;
    logic [AW-1:0]            last_c;
    logic                     search_hit;
    logic                     clamp_zero;
    logic                     clamp_one;
    logic                     div_start;
    logic [AW-1:0]            v_rd_addr;
    logic [DATA_W-1:0]        t_rd_data;
    logic [VEC_W-1:0]         v_rd_data;
    logic [FRAC_W-1:0]        div_quo;
    kvi_pkg::div_stat_t       div_stat;
    kvi_pkg::lerp_ctl_t       lerp_ctl;
    logic signed [DATA_W-1:0] a_sel, b_sel, lerp_res;

    // configuration port
    assign cfg_sel = (paddr[PADDR_W-1:2] == kvi_pkg::REG_KEY_COUNT);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? PDATA_W'(key_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= KC_W'(1);
        end else if (cfg_wr) begin
            key_count_reg <= pwdata[KC_W-1:0];
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign load_wr = s_fire && (s_mode == kvi_pkg::MODE_LOAD)
                     && (int'(s_key_index) < MAX_KEYS);

    always_comb begin
        if (key_count_reg == '0) begin
            last_c = '0;
        end else if (int'(key_count_reg) > MAX_KEYS) begin
            last_c = AW'(MAX_KEYS - 1);
        end else begin
            last_c = AW'(key_count_reg - KC_W'(1));
        end
    end

    assign search_hit = pend_reg && (pend_idx_reg != '0)
                        && ((q_reg < t_rd_data) || (pend_idx_reg == last_reg));
    assign clamp_zero = (den_reg == '0) || num_reg[DATA_W] || (num_reg == '0);
    assign clamp_one  = (num_reg >= den_reg);
    assign div_start  = (state_reg == S_CLAMP) && !clamp_zero && !clamp_one;

    assign v_rd_addr  = ((state_reg == S_VB) && !single_reg) ? seg_reg + 1'b1 : seg_reg;

    assign lerp_ctl.diff_en = (state_reg == S_LDIFF);
    assign lerp_ctl.mul_en  = (state_reg == S_LMUL);

    always_comb begin
        unique case (comp_reg)
            kvi_pkg::COMP_X: begin
                a_sel = a_vec_reg[DATA_W-1:0];
                b_sel = b_vec_reg[DATA_W-1:0];
            end
            kvi_pkg::COMP_Y: begin
                a_sel = a_vec_reg[2*DATA_W-1:DATA_W];
                b_sel = b_vec_reg[2*DATA_W-1:DATA_W];
            end
            default: begin
                a_sel = a_vec_reg[3*DATA_W-1:2*DATA_W];
                b_sel = b_vec_reg[3*DATA_W-1:2*DATA_W];
            end
        endcase
    end

    kvi_key_mem #(
        .MAX_KEYS (MAX_KEYS),
        .AW       (AW)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (load_wr),
        .wr_addr   (AW'(s_key_index)),
        .wr_time   (s_key_time),
        .wr_value  ({s_key_z, s_key_y, s_key_x}),
        .t_rd_addr (probe_reg),
        .t_rd_data (t_rd_data),
        .v_rd_addr (v_rd_addr),
        .v_rd_data (v_rd_data)
    );

    kvi_blend_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg[DATA_W-1:0]),
        .den     (den_reg[DATA_W-1:0]),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    kvi_lerp_mac u_lerp (
        .aclk  (aclk),
        .ctl   (lerp_ctl),
        .a_val (a_sel),
        .b_val (b_sel),
        .blend (blend_reg),
        .res   (lerp_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_mode == kvi_pkg::MODE_QUERY)) begin
                    state_next = (last_c == '0) ? S_VA : S_SRCH;
                end
            end
            S_SRCH: begin
                if (search_hit) begin
                    state_next = S_PREP;
                end
            end
            S_PREP:  state_next = S_NORM;
            S_NORM:  state_next = S_CLAMP;
            S_CLAMP: state_next = div_start ? S_DIV : S_VA;
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = S_VA;
                end
            end
            S_VA:    state_next = S_VB;
            S_VB:    state_next = S_VC;
            S_VC:    state_next = S_LDIFF;
            S_LDIFF: state_next = S_LMUL;
            S_LMUL:  state_next = S_LADD;
            S_LADD:  state_next = (comp_reg == kvi_pkg::COMP_Z) ? S_OUT : S_LDIFF;
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if ((state_reg == S_OUT) && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= (state_reg == S_SRCH);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_mode == kvi_pkg::MODE_QUERY)) begin
                    q_reg      <= s_query_time;
                    last_reg   <= last_c;
                    probe_reg  <= '0;
                    seg_reg    <= '0;
                    single_reg <= (last_c == '0);
                    blend_reg  <= '0;
                end
            end
            S_SRCH: begin
                probe_reg    <= (probe_reg == last_reg) ? probe_reg : probe_reg + 1'b1;
                pend_idx_reg <= probe_reg;
                if (pend_reg) begin
                    if (search_hit) begin
                        ti_reg  <= tprev_reg;
                        tn_reg  <= t_rd_data;
                        seg_reg <= pend_idx_reg - 1'b1;
                    end else begin
                        tprev_reg <= t_rd_data;
                    end
                end
            end
            S_PREP: begin
                num_reg <= $signed({1'b0, q_reg})  - $signed({1'b0, ti_reg});
                den_reg <= $signed({1'b0, tn_reg}) - $signed({1'b0, ti_reg});
            end
            S_NORM: begin
                if (den_reg[DATA_W]) begin
                    num_reg <= -num_reg;
                    den_reg <= -den_reg;
                end
            end
            S_CLAMP: begin
                if (clamp_zero) begin
                    blend_reg <= '0;
                end else if (clamp_one) begin
                    blend_reg <= kvi_pkg::ONE_Q16;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    blend_reg <= {1'b0, div_quo};
                end
            end
            S_VB: begin
                a_vec_reg <= v_rd_data;
            end
            S_VC: begin
                b_vec_reg <= v_rd_data;
                comp_reg  <= kvi_pkg::COMP_X;
            end
            S_LADD: begin
                unique case (comp_reg)
                    kvi_pkg::COMP_X: res_x_reg <= lerp_res;
                    kvi_pkg::COMP_Y: res_y_reg <= lerp_res;
                    default:         res_z_reg <= lerp_res;
                endcase
                comp_reg <= comp_reg + 1'b1;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_x_reg     <= res_x_reg;
                    out_y_reg     <= res_y_reg;
                    out_z_reg     <= res_z_reg;
                    out_seg_reg   <= IDX_W'(seg_reg);
                    out_blend_reg <= blend_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_out_x   = out_x_reg;
    assign m_out_y   = out_y_reg;
    assign m_out_z   = out_z_reg;
    assign m_segment = out_seg_reg;
    assign m_blend   = out_blend_reg;

endmodule

@@ rtl/kvi_key_mem.sv @@
// ----------------------------------------------------------------------------
// Keyframe store
// Time and value memories, one write port, one registered read port each.
// ----------------------------------------------------------------------------
module kvi_key_mem #(
    parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF,
    parameter int AW       = $clog2(MAX_KEYS)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [kvi_pkg::DATA_W-1:0] wr_time,
    input  logic [kvi_pkg::VEC_W-1:0]  wr_value,
    input  logic [AW-1:0]              t_rd_addr,
    output logic [kvi_pkg::DATA_W-1:0] t_rd_data,
    input  logic [AW-1:0]              v_rd_addr,
    output logic [kvi_pkg::VEC_W-1:0]  v_rd_data
);

    logic [kvi_pkg::DATA_W-1:0] time_mem  [MAX_KEYS];
    logic [kvi_pkg::VEC_W-1:0]  value_mem [MAX_KEYS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[wr_addr]  <= wr_time;
            value_mem[wr_addr] <= wr_value;
        end
        t_rd_data <= time_mem[t_rd_addr];
        v_rd_data <= value_mem[v_rd_addr];
    end

endmodule

@@ rtl/kvi_blend_div.sv @@
// ----------------------------------------------------------------------------
// Blend divider
// Restoring divider, one quotient bit per cycle: num * 2^16 / den, num < den.
// ----------------------------------------------------------------------------
module kvi_blend_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [kvi_pkg::DATA_W-1:0] num,
    input  logic [kvi_pkg::DATA_W-1:0] den,
    output logic [kvi_pkg::FRAC_W-1:0] quo,
    output kvi_pkg::div_stat_t         stat
);

    localparam int DATA_W = kvi_pkg::DATA_W;
    localparam int FRAC_W = kvi_pkg::FRAC_W;
    localparam int CNT_W  = kvi_pkg::DIV_CNT_W;

    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   rem_dbl;
    logic [DATA_W:0]   rem_sub;
    logic              fits;

    always_comb begin
        rem_dbl = {rem_reg, 1'b0};
        rem_sub = rem_dbl - {1'b0, den_reg};
        fits    = (rem_dbl >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[DATA_W-1:0] : rem_dbl[DATA_W-1:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/kvi_lerp_mac.sv @@
// ----------------------------------------------------------------------------
// Interpolation unit
// Shared difference, multiply and add, one component at a time.
// ----------------------------------------------------------------------------
module kvi_lerp_mac (
    input  logic                               aclk,
    input  kvi_pkg::lerp_ctl_t                 ctl,
    input  logic signed [kvi_pkg::DATA_W-1:0]  a_val,
    input  logic signed [kvi_pkg::DATA_W-1:0]  b_val,
    input  logic [kvi_pkg::BLEND_W-1:0]        blend,
    output logic signed [kvi_pkg::DATA_W-1:0]  res
);

    localparam int DATA_W  = kvi_pkg::DATA_W;
    localparam int FRAC_W  = kvi_pkg::FRAC_W;
    localparam int PROD_W  = DATA_W + 1 + kvi_pkg::BLEND_W + 1;

    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (ctl.diff_en) begin
            a_reg    <= a_val;
            diff_reg <= $signed({b_val[DATA_W-1], b_val}) - $signed({a_val[DATA_W-1], a_val});
        end
        if (ctl.mul_en) begin
            prod_reg <= diff_reg * $signed({1'b0, blend});
        end
    end

    assign res = a_reg + $signed(prod_reg[FRAC_W+DATA_W-1:FRAC_W]);

endmodule

@@ rtl/kvi_checker.sv @@
// ----------------------------------------------------------------------------
// Keyframe interpolator checker
// Port-level properties of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_vec3_interpolator_unit_macros.svh"

module kvi_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_mode,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [kvi_pkg::DATA_W-1:0]   m_out_x,
    input  logic [kvi_pkg::BLEND_W-1:0]         m_blend
);

    `KVI_ASSERT_NEXT(a_query_busy, s_valid && s_ready && s_mode, !s_ready, "ready after query request")

    `KVI_ASSERT_NEXT(a_load_ready, s_valid && s_ready && !s_mode, s_ready, "not ready after load request")

    `KVI_ASSERT_SAME(a_blend_range, m_valid, m_blend <= kvi_pkg::ONE_Q16, "blend factor above one")

    `KVI_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_out_x) && $stable(m_blend), "stalled result changed")

endmodule

bind keyframe_vec3_interpolator_unit kvi_checker u_kvi_checker (.*);

@@ dv/kvi_track_checker.sv @@
// ----------------------------------------------------------------------------
// Keyframe interpolator track checker
// Watches the register port and the request and result channels, keeps a
// shadow of the key_count register and the keyframe track, predicts the
// sample for every accepted query and compares each accepted result with the
// oldest one.
module kvi_track_checker #(
    parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kvi_pkg::PADDR_W-1:0]       paddr,
    input  logic [kvi_pkg::PDATA_W-1:0]       pwdata,
    input  logic                              pready,

    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_mode,
    input  logic [kvi_pkg::IDX_W-1:0]         s_key_index,
    input  logic [kvi_pkg::DATA_W-1:0]        s_key_time,
    input  logic signed [kvi_pkg::DATA_W-1:0] s_key_x,
    input  logic signed [kvi_pkg::DATA_W-1:0] s_key_y,
    input  logic signed [kvi_pkg::DATA_W-1:0] s_key_z,
    input  logic [kvi_pkg::DATA_W-1:0]        s_query_time,

    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [kvi_pkg::DATA_W-1:0] m_out_x,
    input  logic signed [kvi_pkg::DATA_W-1:0] m_out_y,
    input  logic signed [kvi_pkg::DATA_W-1:0] m_out_z,
    input  logic [kvi_pkg::IDX_W-1:0]         m_segment,
    input  logic [kvi_pkg::BLEND_W-1:0]       m_blend,

    output int                                mismatches,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kvi_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  x;
        logic [DATA_W-1:0]  y;
        logic [DATA_W-1:0]  z;
        logic [IDX_W-1:0]   seg;
        logic [BLEND_W-1:0] blend;
    } sample_t;

    logic [KC_W-1:0]          key_count_reg;
    logic [DATA_W-1:0]        key_times [MAX_KEYS];
    logic signed [DATA_W-1:0] key_xs [MAX_KEYS];
    logic signed [DATA_W-1:0] key_ys [MAX_KEYS];
    logic signed [DATA_W-1:0] key_zs [MAX_KEYS];
    sample_t                  expected_samples [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic longint blend_q16(longint num, longint den);
        if (den == 0)
            return 0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0)
            return 0;
        if (num >= den)
            return longint'(ONE_Q16);
        return (num <<< FRAC_W) / den;
    endfunction

    function automatic logic [DATA_W-1:0] lerp_q16(logic signed [DATA_W-1:0] a,
                                                   logic signed [DATA_W-1:0] b,
                                                   longint f);
        longint la, lb, r;
        la = longint'(a);
        lb = longint'(b);
        r  = la + (((lb - la) * f) >>> FRAC_W);
        return r[DATA_W-1:0];
    endfunction

    function automatic sample_t interp_expected(logic [DATA_W-1:0] qt);
        sample_t s;
        int      n, seg, i;
        bit      found;
        longint  num, den, f;
        n = int'(key_count_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_KEYS)
            n = MAX_KEYS;
        if (n == 1) begin
            s.x     = key_xs[0];
            s.y     = key_ys[0];
            s.z     = key_zs[0];
            s.seg   = '0;
            s.blend = '0;
            return s;
        end
        seg   = n - 2;
        found = 1'b0;
        for (i = 0; i + 1 < n; i++) begin
            if (!found && qt < key_times[i+1]) begin
                seg   = i;
                found = 1'b1;
            end
        end
        num = longint'({32'd0, qt}) - longint'({32'd0, key_times[seg]});
        den = longint'({32'd0, key_times[seg+1]}) - longint'({32'd0, key_times[seg]});
        f   = blend_q16(num, den);
        s.x     = lerp_q16(key_xs[seg], key_xs[seg+1], f);
        s.y     = lerp_q16(key_ys[seg], key_ys[seg+1], f);
        s.z     = lerp_q16(key_zs[seg], key_zs[seg+1], f);
        s.seg   = IDX_W'(seg);
        s.blend = BLEND_W'(f);
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t kvi mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_sample(sample_t got, sample_t want);
        if (got.x !== want.x)
            report_mismatch("out_x", got.x, want.x);
        if (got.y !== want.y)
            report_mismatch("out_y", got.y, want.y);
        if (got.z !== want.z)
            report_mismatch("out_z", got.z, want.z);
        if (got.seg !== want.seg)
            report_mismatch("segment", got.seg, want.seg);
        if (got.blend !== want.blend)
            report_mismatch("blend", got.blend, want.blend);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg = KC_W'(1);
            expected_samples.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[PADDR_W-1:2] == REG_KEY_COUNT)
                key_count_reg = pwdata[KC_W-1:0];
            if (s_valid && s_ready) begin
                if (s_mode == MODE_LOAD) begin
                    if (s_key_index < MAX_KEYS) begin
                        key_times[s_key_index] = s_key_time;
                        key_xs[s_key_index]    = s_key_x;
                        key_ys[s_key_index]    = s_key_y;
                        key_zs[s_key_index]    = s_key_z;
                    end
                end else begin
                    expected_samples.insert(expected_samples.size(),
                                            interp_expected(s_query_time));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0)
                    report_mismatch("result with no query waiting", m_blend, '0);
                else
                    compare_sample({m_out_x, m_out_y, m_out_z, m_segment, m_blend},
                                   expected_samples.pop_front());
            end
        end
        pending = expected_samples.size();
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Keyframe interpolator testbench
// Loads keyframe tracks, sweeps key_count through its extremes and out of
// range values, and sends directed then random query and load requests with
// random gaps and output stalls; the track checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kvi_pkg::*;

    localparam int NKEYS = MAX_KEYS_DEF;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_KEY_COUNT + 1'b1;

    logic                     aclk;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_mode;
    logic [IDX_W-1:0]         s_key_index;
    logic [DATA_W-1:0]        s_key_time;
    logic signed [DATA_W-1:0] s_key_x;
    logic signed [DATA_W-1:0] s_key_y;
    logic signed [DATA_W-1:0] s_key_z;
    logic [DATA_W-1:0]        s_query_time;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_out_x;
    logic signed [DATA_W-1:0] m_out_y;
    logic signed [DATA_W-1:0] m_out_z;
    logic [IDX_W-1:0]         m_segment;
    logic [BLEND_W-1:0]       m_blend;

    int                       track_mismatches;
    int                       track_pending;
    bit                       calm;
    bit                       long_hold_go;
    bit                       long_hold_done;
    logic [DATA_W-1:0]        track_times [NKEYS];

    keyframe_vec3_interpolator_unit #(.MAX_KEYS(NKEYS)) uut (.*);

    kvi_track_checker #(.MAX_KEYS(NKEYS)) track_chk (
        .mismatches(track_mismatches),
        .pending   (track_pending),
        .*
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int r, len;
        m_ready        = 1'b0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_go && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (calm || r < 55) begin
                    m_ready <= 1'b1;
                    len = $urandom_range(1, 30);
                end else if (r < 90) begin
                    m_ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    m_ready <= 1'b0;
                    len = $urandom_range(10, 50);
                end
                repeat (len - 1) @(negedge aclk);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int eff_keys(logic [KC_W-1:0] kc);
        if (kc == 0)
            return 1;
        if (kc > NKEYS)
            return NKEYS;
        return int'(kc);
    endfunction

    function automatic logic [DATA_W-1:0] pick_query(int n);
        int r, k;
        k = $urandom_range(0, n - 1);
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom;
        if (r < 65)
            return track_times[k] + DATA_W'($urandom_range(0, 2)) - 1;
        if (r < 75)
            return '0;
        if (r < 82)
            return '1;
        return track_times[k] + DATA_W'($urandom_range(0, 1 << 16));
    endfunction

    task automatic send_req(logic mode, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] kt,
                            logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                            logic [DATA_W-1:0] z, logic [DATA_W-1:0] qt);
        int gap;
        gap = sender_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_key_index  <= idx;
        s_key_time   <= kt;
        s_key_x      <= x;
        s_key_y      <= y;
        s_key_z      <= z;
        s_query_time <= qt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_key(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] kt,
                            logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                            logic [DATA_W-1:0] z);
        track_times[idx] = kt;
        send_req(MODE_LOAD, idx, kt, x, y, z, $urandom);
    endtask

    task automatic query_at(logic [DATA_W-1:0] qt);
        send_req(MODE_QUERY, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom, qt);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] reg_idx, logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_key_count(logic [KC_W-1:0] kc, bit poke_unused);
        logic [PDATA_W-1:0] data;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (track_pending != 0) @(negedge aclk);
        repeat (110) @(negedge aclk);
        data = PDATA_W'(kc);
        if ($urandom_range(0, 1))
            data[PDATA_W-1:KC_W] = (PDATA_W - KC_W)'($urandom);
        apb_write(REG_KEY_COUNT, data);
        if (poke_unused)
            apb_write(REG_UNUSED, $urandom);
    endtask

    task automatic build_track(int n);
        logic [DATA_W-1:0] t, step_max;
        int                i, r;
        t        = $urandom_range(0, 1 << 20);
        step_max = 32'hF000_0000 / n;
        for (i = 0; i < n; i++) begin
            load_key(IDX_W'(i), t, pick_value(), pick_value(), pick_value());
            r = $urandom_range(0, 9);
            if (r < 3)
                t = t + DATA_W'($urandom_range(1, 1 << 16));
            else if (r > 0)
                t = t + DATA_W'($urandom_range(1, step_max));
        end
    endtask

    task automatic mix_requests(int n, int count);
        int j, r, slot;
        for (j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                query_at(pick_query(n));
            end else if (r < 85) begin
                load_key(IDX_W'($urandom_range(0, NKEYS - 1)), $urandom,
                         pick_value(), pick_value(), pick_value());
            end else begin
                slot = $urandom_range(0, n - 1);
                load_key(IDX_W'(slot), track_times[$urandom_range(0, n - 1)]
                         + DATA_W'($urandom_range(0, 2)) - 1,
                         pick_value(), pick_value(), pick_value());
            end
        end
    endtask

    initial begin
        logic [KC_W-1:0] kc_sweep [9];
        int              p, n;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_mode       = MODE_LOAD;
        s_key_index  = '0;
        s_key_time   = '0;
        s_key_x      = '0;
        s_key_y      = '0;
        s_key_z      = '0;
        s_query_time = '0;
        calm         = 1'b0;
        long_hold_go = 1'b0;
        kc_sweep     = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd64, 7'd9, 7'd33, 7'd5};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single-key track at the reset count
        load_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);

        // four keys, last segment of zero length
        set_key_count(7'd4, 1'b1);
        load_key(0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        load_key(1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
        load_key(2, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        load_key(3, 32'h8000_0000, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_0000);
        query_at(32'h0000_0000);
        query_at(32'h0001_0000);
        query_at(32'h0001_FFFF);
        query_at(32'h0002_0000);
        query_at(32'h4000_0000);
        query_at(32'h8000_0000);
        query_at(32'hFFFF_FFFF);

        // unsorted: first key later than the second
        load_key(0, 32'hC000_0000, 32'h0000_0000, 32'h0001_0000, 32'h8000_0000);
        query_at(32'h0001_0000);
        query_at(32'hFFFF_FFFF);
        set_key_count(7'd2, 1'b0);
        query_at(32'h9000_0000);
        query_at(32'h4000_0000);

        for (p = 0; p < 9; p++) begin
            set_key_count(kc_sweep[p], $urandom_range(0, 3) == 0);
            n    = eff_keys(kc_sweep[p]);
            calm = (p == 5);
            build_track(n);
            if (p == 0) begin
                mix_requests(n, 10);
                long_hold_go = 1'b1;
                mix_requests(n, 25);
            end else begin
                mix_requests(n, 35);
            end
            calm = 1'b0;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (track_pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
        if (track_mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/kvi_pkg.sv
rtl/kvi_key_mem.sv
rtl/kvi_blend_div.sv
rtl/kvi_lerp_mac.sv
rtl/keyframe_vec3_interpolator_unit.sv
rtl/kvi_checker.sv
dv/kvi_track_checker.sv
dv/tb_top.sv
